FILE: hw/rtl/fbpa_pkg.sv
// Shared types and constants for the fixed-size block pool allocator.
package fbpa_pkg;

	// Pool size and derived widths
	localparam int NUM_BLOCKS = 32;
	localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

	// Fixed port field widths
	localparam int REQ_IDX_W  = 6;
	localparam int RSP_IDX_W  = 5;
	localparam int STATUS_W   = 2;
	localparam int S_DATA_W   = 8;
	localparam int M_DATA_W   = 8;

	// Operation codes carried in s_tuser
	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EXHAUSTED = 2'd1,
		STAT_OUTSIDE   = 2'd2,
		STAT_DOUBLE    = 2'd3
	} status_t;

	// Controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_LINK = 1'b1
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;     // item taken this cycle, apply checks and updates
		logic link_load;  // load the new list head from the link read
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic pop_go;     // pending item is an allocate that will pop the list
	} dp_sts_t;

endpackage

FILE: hw/rtl/fixed_block_pool_allocator.sv
// Top level of the fixed-size block pool allocator: controller plus datapath.
//
//  channel   dir  fields (lowest bit first)
//  s_*       in   tuser: func; tdata: block_index[5:0], pad[7:6]
//  m_*       out  tdata: alloc_index[4:0], status[6:5], pad[7]
//
// A free and an allocate on an empty list finish when taken; an allocate that pops
// the list then enters the link state to load the new head from the link read.
// Results sit in an output register; a new item is taken while one waits if
// m_tready takes it in the same cycle.
// Reset gives a full list in ascending order with no clearing pass: links of
// blocks never handed out are implied by a fill pointer.
module fixed_block_pool_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fbpa_pkg::S_DATA_W-1:0] s_tdata,  // block_index[5:0], zero[7:6]
	input  logic                          s_tuser,  // func
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fbpa_pkg::M_DATA_W-1:0] m_tdata   // alloc_index[4:0], status[6:5], zero[7]
);
	import fbpa_pkg::*;

	dp_cmd_t              cmd;
	dp_sts_t              sts;
	logic [RSP_IDX_W-1:0] alloc_index;
	logic [STATUS_W-1:0]  status;

	fbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fbpa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (s_tuser),
		.block_index (s_tdata[REQ_IDX_W-1:0]),
		.cmd         (cmd),
		.sts         (sts),
		.alloc_index (alloc_index),
		.status      (status)
	);

	// Pack the result
	assign m_tdata = M_DATA_W'({status, alloc_index});

endmodule

FILE: hw/rtl/fbpa_ctrl.sv
// Controller state machine and output valid for the block pool allocator.
module fbpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  fbpa_pkg::dp_sts_t sts,
	output fbpa_pkg::dp_cmd_t cmd
);
	import fbpa_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   take;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.link_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready   = !m_tvalid_q || m_tready;
				cmd.accept = s_tvalid && s_tready;
				if (cmd.accept && sts.pop_go) begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				cmd.link_load = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output valid: set when an item is taken, cleared when the result leaves
	assign take = cmd.accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

`ifndef SYNTHESIS
	// A head update always follows a popping allocate in the next cycle
	a_link_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.pop_go |=> cmd.link_load)
		else $error("link load missing after pop");

	// No item is taken while the head update is pending
	a_no_accept_in_link: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link_load |-> !cmd.accept)
		else $error("item accepted during link load");

	// A taken item always produces a waiting result
	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> m_tvalid)
		else $error("no result after accept");
`endif

endmodule

FILE: hw/rtl/fbpa_dp.sv
// Datapath: free list head, link memory, allocated marks and result register.
module fbpa_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           func,
	input  logic [fbpa_pkg::REQ_IDX_W-1:0] block_index,
	input  fbpa_pkg::dp_cmd_t              cmd,
	output fbpa_pkg::dp_sts_t              sts,
	output logic [fbpa_pkg::RSP_IDX_W-1:0] alloc_index,
	output logic [fbpa_pkg::STATUS_W-1:0]  status
);
	import fbpa_pkg::*;

	// List state
	logic [IDX_W-1:0]      head_q;
	logic                  nonempty_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      fresh_q;      // blocks below this were handed out at least once
	logic [NUM_BLOCKS-1:0] mark_q;

	// Link memory and its read path
	logic [IDX_W-1:0]      link_mem [NUM_BLOCKS];
	logic [IDX_W-1:0]      link_rd_q;
	logic                  link_fresh_q;
	logic [IDX_W-1:0]      link_inc_q;

	// Result register
	logic [RSP_IDX_W-1:0]  out_index_q;
	status_t               out_status_q;

	logic [IDX_W-1:0]      idx;
	logic                  outside;
	logic                  pop_go;
	logic                  push_go;
	logic                  head_fresh;
	logic [IDX_W-1:0]      head_inc;
	status_t               stat;

	// Request checks
	always_comb begin
		idx        = IDX_W'(block_index);
		outside    = 32'(block_index) >= 32'(NUM_BLOCKS);
		pop_go     = (func == FUNC_ALLOC) && nonempty_q;
		push_go    = (func == FUNC_FREE) && !outside && mark_q[idx];
		head_fresh = CNT_W'(head_q) == fresh_q;
		head_inc   = (head_q == IDX_W'(NUM_BLOCKS - 1)) ? '0 : head_q + 1'b1;
		if (func == FUNC_ALLOC) begin
			stat = nonempty_q ? STAT_OK : STAT_EXHAUSTED;
		end else if (outside) begin
			stat = STAT_OUTSIDE;
		end else if (!mark_q[idx]) begin
			stat = STAT_DOUBLE;
		end else begin
			stat = STAT_OK;
		end
	end

	assign sts.pop_go = pop_go;

	// Head, counts and marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			nonempty_q <= 1'b1;
			count_q    <= CNT_W'(NUM_BLOCKS);
			fresh_q    <= '0;
			mark_q     <= '0;
		end else if (cmd.accept) begin
			if (pop_go) begin
				mark_q[head_q] <= 1'b1;
				count_q        <= count_q - 1'b1;
				nonempty_q     <= count_q != CNT_W'(1);
				if (head_fresh) begin
					fresh_q <= fresh_q + 1'b1;
				end
			end
			if (push_go) begin
				mark_q[idx] <= 1'b0;
				count_q     <= count_q + 1'b1;
				nonempty_q  <= 1'b1;
				head_q      <= idx;
			end
		end else if (cmd.link_load) begin
			// Untouched blocks link to the next index
			head_q <= link_fresh_q ? link_inc_q : link_rd_q;
		end
	end

	// Link memory: write on push, registered read at the head
	always_ff @(posedge clk) begin
		if (cmd.accept && push_go) begin
			link_mem[idx] <= head_q;
		end
		link_rd_q    <= link_mem[head_q];
		link_fresh_q <= head_fresh;
		link_inc_q   <= head_inc;
	end

	// Result capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			out_index_q  <= pop_go ? RSP_IDX_W'(head_q) : '0;
			out_status_q <= stat;
		end
	end

	assign alloc_index = out_index_q;
	assign status      = out_status_q;

`ifndef SYNTHESIS
	// Every block is either free or marked allocated
	a_count_marks: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(mark_q) + int'(count_q) == NUM_BLOCKS)
		else $error("free count and marks disagree");

	// List flag tracks the free count
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q == (count_q != '0))
		else $error("nonempty flag out of step with count");

	// A successful free clears that block's mark
	a_push_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && push_go |=> !mark_q[$past(idx)])
		else $error("freed block still marked");

	// Fresh pointer never passes the pool
	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fresh_q) <= NUM_BLOCKS)
		else $error("fresh pointer out of range");
`endif

endmodule
